>>> rtl/core/srwc_pkg.sv
// ----------------------------------------------------------------------------
// srwc_pkg
// Shared types, constants and the CRC-8 byte update for the sensor response
// word checker.
// ----------------------------------------------------------------------------
package srwc_pkg;

  // frame layout
  localparam int unsigned WORD_COUNT = 9;
  localparam int unsigned WORD_IDX_W = $clog2(WORD_COUNT);
  localparam logic [WORD_IDX_W-1:0] LAST_WORD = WORD_IDX_W'(WORD_COUNT - 1);

  // crc and sentinel constants
  localparam logic [7:0]  CRC_POLY    = 8'h31;
  localparam logic [7:0]  SEED_RESET  = 8'hFF;
  localparam logic [15:0] U_SENTINEL  = 16'hFFFF;
  localparam logic [15:0] S_SENTINEL  = 16'h7FFF;

  // byte role inside a word
  typedef enum logic [1:0] {
    PH_HIGH = 2'd0,
    PH_LOW  = 2'd1,
    PH_CRC  = 2'd2
  } phase_t;

  typedef logic [WORD_COUNT-1:0][15:0] word_array_t;

  // status from the frame tracker for the byte on the input
  typedef struct packed {
    logic last;   // byte closes a response
    logic good;   // all word crcs matched, valid with last
  } frame_status_t;

  // crc-8, msb first, no reflection, no final xor
  function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int i = 0; i < 8; i++) begin
      if (c[7]) begin
        c = {c[6:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

>>> rtl/core/srwc_frame_track.sv
// ----------------------------------------------------------------------------
// srwc_frame_track
// Follows the byte position in a response, runs the per-word CRC-8 and
// stages the received data words.
// ----------------------------------------------------------------------------
module srwc_frame_track (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        take,
  input  logic [7:0]                  rx_byte,
  input  logic                        frame_start,
  input  logic [7:0]                  crc_seed,
  output srwc_pkg::frame_status_t     status,
  output srwc_pkg::word_array_t       staged
);

  srwc_pkg::phase_t                     phase_r, phase_nxt, phase_eff;
  logic [srwc_pkg::WORD_IDX_W-1:0]      word_r, word_nxt, word_eff;
  logic [7:0]                           crc_r, crc_nxt, crc_base;
  logic                                 bad_r, bad_nxt, bad_eff;
  logic [7:0]                           high_r;
  logic                                 crc_miss;
  logic                                 is_last;
  srwc_pkg::word_array_t                staged_r;

  // a frame start forces the first position and clears the error flag
  always_comb begin
    phase_eff = frame_start ? srwc_pkg::PH_HIGH : phase_r;
    word_eff  = frame_start ? '0 : word_r;
    bad_eff   = frame_start ? 1'b0 : bad_r;
    crc_base  = (phase_eff == srwc_pkg::PH_HIGH) ? crc_seed : crc_r;
    crc_miss  = (crc_r != rx_byte);
    is_last   = (phase_eff == srwc_pkg::PH_CRC) && (word_eff == srwc_pkg::LAST_WORD);
  end

  // next position, crc and error flag
  always_comb begin
    phase_nxt = phase_eff;
    word_nxt  = word_eff;
    crc_nxt   = crc_r;
    bad_nxt   = bad_eff;
    case (phase_eff)
      srwc_pkg::PH_HIGH: begin
        crc_nxt   = srwc_pkg::crc8_byte(crc_base, rx_byte);
        phase_nxt = srwc_pkg::PH_LOW;
      end
      srwc_pkg::PH_LOW: begin
        crc_nxt   = srwc_pkg::crc8_byte(crc_base, rx_byte);
        phase_nxt = srwc_pkg::PH_CRC;
      end
      srwc_pkg::PH_CRC: begin
        phase_nxt = srwc_pkg::PH_HIGH;
        if (is_last) begin
          word_nxt = '0;
          bad_nxt  = 1'b0;
        end else begin
          word_nxt = word_eff + 1'b1;
          bad_nxt  = bad_eff | crc_miss;
        end
      end
      default: begin
        phase_nxt = srwc_pkg::PH_HIGH;
        word_nxt  = '0;
        bad_nxt   = 1'b0;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= srwc_pkg::PH_HIGH;
      word_r  <= '0;
      crc_r   <= srwc_pkg::SEED_RESET;
      bad_r   <= 1'b0;
    end else if (take) begin
      phase_r <= phase_nxt;
      word_r  <= word_nxt;
      crc_r   <= crc_nxt;
      bad_r   <= bad_nxt;
    end
  end

  // high byte hold and staged words
  always_ff @(posedge clk) begin
    if (take && (phase_eff == srwc_pkg::PH_HIGH)) begin
      high_r <= rx_byte;
    end
    if (take && (phase_eff == srwc_pkg::PH_LOW)) begin
      staged_r[word_eff] <= {high_r, rx_byte};
    end
  end

  assign status.last = is_last;
  assign status.good = !(bad_eff | crc_miss);
  assign staged      = staged_r;

endmodule

>>> rtl/core/sensor_response_word_checker.sv
// ----------------------------------------------------------------------------
// sensor_response_word_checker
// Checks the nine CRC-8 protected words of a 27-byte sensor response and
// publishes the readings when every word is good.
// ----------------------------------------------------------------------------
//  channel | direction | handshake           | payload
//  in_     | in        | in_valid / in_stall | in_rx_byte, in_frame_start
//  out_    | out       | out_valid/out_stall | nine readings, out_frame_good
//  cfg_    | in        | cfg_wr_en           | cfg_wr_data (crc seed)
//
// One byte is taken per cycle; the crc update and position step sit between
// the input and the registered readings. The result appears in the cycle
// after the closing byte of a response. Only a closing byte is stalled, and
// only while an earlier result is still waiting. Reset (rst_n, synchronous)
// clears the position, error flag and readings and sets the seed to 0xFF.
// ----------------------------------------------------------------------------
module sensor_response_word_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_wr_en,
  input  logic [7:0]         cfg_wr_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [7:0]         in_rx_byte,
  input  logic               in_frame_start,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [15:0]        out_pm1_reading,
  output logic [15:0]        out_pm25_reading,
  output logic [15:0]        out_pm4_reading,
  output logic [15:0]        out_pm10_reading,
  output logic signed [15:0] out_humidity_reading,
  output logic signed [15:0] out_temperature_reading,
  output logic signed [15:0] out_voc_reading,
  output logic signed [15:0] out_nox_reading,
  output logic [15:0]        out_hcho_reading,
  output logic               out_frame_good
);

  logic                    [7:0] seed_r;
  logic                          take;
  logic                          close;
  srwc_pkg::frame_status_t       status;
  srwc_pkg::word_array_t         staged;
  srwc_pkg::word_array_t         pub_r, pub_nxt;
  logic                          out_valid_r, out_valid_nxt;
  logic                          good_r;

  // crc seed register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seed_r <= srwc_pkg::SEED_RESET;
    end else if (cfg_wr_en) begin
      seed_r <= cfg_wr_data;
    end
  end

  // handshake
  assign in_stall = out_valid_r && out_stall && status.last;
  assign take     = in_valid && !in_stall;
  assign close    = take && status.last;

  srwc_frame_track u_track (
    .clk         (clk),
    .rst_n       (rst_n),
    .take        (take),
    .rx_byte     (in_rx_byte),
    .frame_start (in_frame_start),
    .crc_seed    (seed_r),
    .status      (status),
    .staged      (staged)
  );

  // sentinel replacement, signed words are four to seven
  always_comb begin
    for (int k = 0; k < srwc_pkg::WORD_COUNT; k++) begin
      if ((k >= 4) && (k <= 7)) begin
        pub_nxt[k] = (staged[k] == srwc_pkg::S_SENTINEL) ? 16'h0000 : staged[k];
      end else begin
        pub_nxt[k] = (staged[k] == srwc_pkg::U_SENTINEL) ? 16'h0000 : staged[k];
      end
    end
  end

  // result valid
  always_comb begin
    if (close) begin
      out_valid_nxt = 1'b1;
    end else if (out_stall) begin
      out_valid_nxt = out_valid_r;
    end else begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      pub_r       <= '0;
      good_r      <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (close) begin
        good_r <= status.good;
        if (status.good) begin
          pub_r <= pub_nxt;
        end
      end
    end
  end

  assign out_valid               = out_valid_r;
  assign out_frame_good          = good_r;
  assign out_pm1_reading         = pub_r[0];
  assign out_pm25_reading        = pub_r[1];
  assign out_pm4_reading         = pub_r[2];
  assign out_pm10_reading        = pub_r[3];
  assign out_humidity_reading    = signed'(pub_r[4]);
  assign out_temperature_reading = signed'(pub_r[5]);
  assign out_voc_reading         = signed'(pub_r[6]);
  assign out_nox_reading         = signed'(pub_r[7]);
  assign out_hcho_reading        = pub_r[8];

endmodule

>>> rtl/core/srwc_checker.sv
// ----------------------------------------------------------------------------
// srwc_checker
// Port-level checks for the sensor response word checker, bound to the top.
// ----------------------------------------------------------------------------
module srwc_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input logic [15:0]        out_pm1_reading,
  input logic [15:0]        out_pm25_reading,
  input logic [15:0]        out_pm4_reading,
  input logic [15:0]        out_pm10_reading,
  input logic signed [15:0] out_humidity_reading,
  input logic signed [15:0] out_temperature_reading,
  input logic signed [15:0] out_voc_reading,
  input logic signed [15:0] out_nox_reading,
  input logic [15:0]        out_hcho_reading,
  input logic               out_frame_good
);

  // a waiting result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_pm1_reading)
      && $stable(out_humidity_reading) && $stable(out_frame_good))
    else $error("waiting result changed");

  // input is only held back by a blocked result
  a_stall: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without a blocked result");

  // a new result follows an accepted byte
  a_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && !in_stall))
    else $error("result without an accepted byte");

  // sentinels never reach the readings
  a_sentinel: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_pm1_reading != 16'hFFFF) && (out_pm25_reading != 16'hFFFF)
      && (out_pm4_reading != 16'hFFFF) && (out_pm10_reading != 16'hFFFF)
      && (out_hcho_reading != 16'hFFFF) && (out_humidity_reading != 16'sh7FFF)
      && (out_temperature_reading != 16'sh7FFF) && (out_voc_reading != 16'sh7FFF)
      && (out_nox_reading != 16'sh7FFF))
    else $error("sentinel value in readings");

  // nothing valid straight out of reset
  a_reset: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind sensor_response_word_checker srwc_checker u_srwc_checker (
  .clk                     (clk),
  .rst_n                   (rst_n),
  .in_valid                (in_valid),
  .in_stall                (in_stall),
  .out_valid               (out_valid),
  .out_stall               (out_stall),
  .out_pm1_reading         (out_pm1_reading),
  .out_pm25_reading        (out_pm25_reading),
  .out_pm4_reading         (out_pm4_reading),
  .out_pm10_reading        (out_pm10_reading),
  .out_humidity_reading    (out_humidity_reading),
  .out_temperature_reading (out_temperature_reading),
  .out_voc_reading         (out_voc_reading),
  .out_nox_reading         (out_nox_reading),
  .out_hcho_reading        (out_hcho_reading),
  .out_frame_good          (out_frame_good)
);

>>> bench/tb_sensor_response_word_checker.sv
// ----------------------------------------------------------------------------
// tb_sensor_response_word_checker
// Self-checking bench for the sensor response word checker. Responses are
// sent byte by byte with bursty input timing while the result side stalls on
// its own pattern. A local model of the framing, the per-word crc-8 and the
// reading publication predicts every result, and a checker compares each
// accepted result with the oldest prediction. Directed tests cover crc
// failures, sentinel words, restarts, wrap-around and seed changes; a random
// phase mixes well-formed responses with broken ones and line noise.
// ----------------------------------------------------------------------------
module tb_sensor_response_word_checker;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned FRAME_LEN    = 27;
  localparam int unsigned RANDOM_BYTES = 1000;
  localparam int unsigned IDLE_LIMIT   = 5000;
  localparam int unsigned DRAIN_CYCLES = 4;

  typedef struct packed {
    srwc_pkg::word_array_t words;
    logic                  good;
  } readings_t;

  // block ports
  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               cfg_wr_en = 1'b0;
  logic [7:0]         cfg_wr_data = 8'h00;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [7:0]         in_rx_byte = 8'h00;
  logic               in_frame_start = 1'b0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [15:0]        out_pm1_reading;
  logic [15:0]        out_pm25_reading;
  logic [15:0]        out_pm4_reading;
  logic [15:0]        out_pm10_reading;
  logic signed [15:0] out_humidity_reading;
  logic signed [15:0] out_temperature_reading;
  logic signed [15:0] out_voc_reading;
  logic signed [15:0] out_nox_reading;
  logic [15:0]        out_hcho_reading;
  logic               out_frame_good;

  // checker model state
  logic [7:0]            mdl_seed;
  logic [4:0]            mdl_pos;
  logic [7:0]            mdl_crc;
  logic                  mdl_bad;
  logic [7:0]            mdl_hold;
  srwc_pkg::word_array_t mdl_staged;
  srwc_pkg::word_array_t mdl_published;

  readings_t pending_readings[$];

  int errors = 0;
  int bytes_sent = 0;
  int good_results = 0;
  int flagged_results = 0;
  int seed_writes = 0;
  int burst_left = 0;
  int idle_cycles = 0;
  logic [7:0] stall_tick = 8'h00;
  logic [1:0] stall_mode = 2'd0;

  sensor_response_word_checker uut (
    .clk                     (clk),
    .rst_n                   (rst_n),
    .cfg_wr_en               (cfg_wr_en),
    .cfg_wr_data             (cfg_wr_data),
    .in_valid                (in_valid),
    .in_stall                (in_stall),
    .in_rx_byte              (in_rx_byte),
    .in_frame_start          (in_frame_start),
    .out_valid               (out_valid),
    .out_stall               (out_stall),
    .out_pm1_reading         (out_pm1_reading),
    .out_pm25_reading        (out_pm25_reading),
    .out_pm4_reading         (out_pm4_reading),
    .out_pm10_reading        (out_pm10_reading),
    .out_humidity_reading    (out_humidity_reading),
    .out_temperature_reading (out_temperature_reading),
    .out_voc_reading         (out_voc_reading),
    .out_nox_reading         (out_nox_reading),
    .out_hcho_reading        (out_hcho_reading),
    .out_frame_good          (out_frame_good)
  );

  // clock
  always #5 clk = ~clk;

  // crc-8 over one byte, bit-serial, msb first
  function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] data);
    logic [7:0] c;
    logic       fb;
    c = crc;
    for (int i = 7; i >= 0; i--) begin
      fb = c[7] ^ data[i];
      c = {c[6:0], 1'b0};
      if (fb) begin
        c = c ^ srwc_pkg::CRC_POLY;
      end
    end
    return c;
  endfunction

  // crc byte that a sensor would send for a word under the current seed
  function automatic logic [7:0] word_crc(input logic [15:0] w);
    return crc8_step(crc8_step(mdl_seed, w[15:8]), w[7:0]);
  endfunction

  function automatic void reset_model();
    mdl_seed      = srwc_pkg::SEED_RESET;
    mdl_pos       = '0;
    mdl_crc       = srwc_pkg::SEED_RESET;
    mdl_bad       = 1'b0;
    mdl_hold      = '0;
    mdl_staged    = '0;
    mdl_published = '0;
  endfunction

  // advance the model by one accepted byte, queue a result on a closing byte
  function automatic void advance_model(input logic [7:0] b, input logic fs);
    srwc_pkg::phase_t ph;
    int unsigned      widx;
    logic [15:0]      w;
    logic             is_signed;
    readings_t        r;
    if (fs) begin
      mdl_pos = '0;
      mdl_bad = 1'b0;
    end
    if (mdl_pos >= FRAME_LEN) begin
      mdl_pos = '0;
    end
    ph   = srwc_pkg::phase_t'(mdl_pos % 3);
    widx = mdl_pos / 3;
    case (ph)
      srwc_pkg::PH_HIGH: begin
        mdl_hold = b;
        mdl_crc  = crc8_step(mdl_seed, b);
      end
      srwc_pkg::PH_LOW: begin
        mdl_crc = crc8_step(mdl_crc, b);
        mdl_staged[widx] = {mdl_hold, b};
      end
      default: begin
        if (mdl_crc != b) begin
          mdl_bad = 1'b1;
        end
      end
    endcase
    if (mdl_pos + 1 < FRAME_LEN) begin
      mdl_pos = mdl_pos + 5'd1;
    end else begin
      if (!mdl_bad) begin
        for (int k = 0; k < srwc_pkg::WORD_COUNT; k++) begin
          w = mdl_staged[k];
          is_signed = (k >= 4 && k <= 7);
          if (is_signed ? (w == srwc_pkg::S_SENTINEL) : (w == srwc_pkg::U_SENTINEL)) begin
            w = '0;
          end
          mdl_published[k] = w;
        end
      end
      r.words = mdl_published;
      r.good  = !mdl_bad;
      pending_readings.push_back(r);
      mdl_pos = '0;
      mdl_bad = 1'b0;
    end
  endfunction

  // result side stall pattern, mode re-drawn whenever the tick's low seven bits are zero
  always @(posedge clk) begin
    stall_tick <= stall_tick + 8'd1;
    if (stall_tick[6:0] == 7'd0) begin
      stall_mode <= 2'($urandom_range(0, 3));
    end
    case (stall_mode)
      2'd0: out_stall <= 1'b0;
      2'd1: out_stall <= (stall_tick[1:0] == 2'd0);
      2'd2: out_stall <= 1'($urandom_range(0, 1));
      default: out_stall <= stall_tick[4];
    endcase
  end

  task automatic check_field(input string name, input logic [15:0] exp_v,
                             input logic [15:0] act_v);
    if (act_v !== exp_v) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $realtime, name, exp_v, act_v);
      errors++;
    end
  endtask

  // result checker
  always @(posedge clk) begin
    readings_t exp_r;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_readings.size() == 0) begin
        $display("%0t: result with nothing expected, actual good=%b pm1=%h",
                 $realtime, out_frame_good, out_pm1_reading);
        errors++;
      end else begin
        exp_r = pending_readings.pop_front();
        check_field("pm1", exp_r.words[0], out_pm1_reading);
        check_field("pm25", exp_r.words[1], out_pm25_reading);
        check_field("pm4", exp_r.words[2], out_pm4_reading);
        check_field("pm10", exp_r.words[3], out_pm10_reading);
        check_field("humidity", exp_r.words[4], out_humidity_reading);
        check_field("temperature", exp_r.words[5], out_temperature_reading);
        check_field("voc", exp_r.words[6], out_voc_reading);
        check_field("nox", exp_r.words[7], out_nox_reading);
        check_field("hcho", exp_r.words[8], out_hcho_reading);
        check_field("frame_good", 16'(exp_r.good), 16'(out_frame_good));
        if (exp_r.good) begin
          good_results++;
        end else begin
          flagged_results++;
        end
      end
    end
  end

  // watchdog on cycles without any handshake
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t: no handshake for %0d cycles", $realtime, IDLE_LIMIT);
      $display("CHECK FAILED");
      $finish;
    end
  end

  // send one byte, with bursts and random gaps in between
  task automatic send_byte(input logic [7:0] b, input logic fs);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
    in_valid       <= 1'b1;
    in_rx_byte     <= b;
    in_frame_start <= fs;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    advance_model(b, fs);
    bytes_sent++;
  endtask

  // seed write, only once no result is outstanding and the pipe has settled
  task automatic write_seed(input logic [7:0] v);
    in_valid <= 1'b0;
    while (pending_readings.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    mdl_seed = v;
    seed_writes++;
    cfg_wr_en <= 1'b0;
  endtask

  // send the first nbytes of a response; words in bad_mask get a broken crc
  task automatic send_frame(input srwc_pkg::word_array_t w, input logic [8:0] bad_mask,
                            input logic use_fs, input int nbytes);
    logic [7:0] c;
    int         k;
    for (int i = 0; i < nbytes; i++) begin
      k = i / 3;
      case (srwc_pkg::phase_t'(i % 3))
        srwc_pkg::PH_HIGH: begin
          c = word_crc(w[k]);
          if (bad_mask[k]) begin
            c = c ^ 8'($urandom_range(1, 255));
          end
          send_byte(w[k][15:8], use_fs && (i == 0));
        end
        srwc_pkg::PH_LOW: send_byte(w[k][7:0], 1'b0);
        default: send_byte(c, 1'b0);
      endcase
    end
  endtask

  // random word, biased towards sentinels and extremes
  function automatic logic [15:0] pick_word(input int slot);
    logic is_signed;
    is_signed = (slot >= 4 && slot <= 7);
    case ($urandom_range(0, 9))
      0: return is_signed ? srwc_pkg::S_SENTINEL : srwc_pkg::U_SENTINEL;
      1: return is_signed ? srwc_pkg::U_SENTINEL : srwc_pkg::S_SENTINEL;
      2: return 16'h0000;
      3: return 16'h8000;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic srwc_pkg::word_array_t random_words();
    srwc_pkg::word_array_t w;
    for (int k = 0; k < srwc_pkg::WORD_COUNT; k++) begin
      w[k] = pick_word(k);
    end
    return w;
  endfunction

  // crc failures straight after reset give zeros, then keep the last good set
  task automatic test_crc_failure();
    srwc_pkg::word_array_t w;
    w = random_words();
    send_frame(w, 9'b000010000, 1'b1, FRAME_LEN);
    send_frame(w, 9'b111111111, 1'b1, FRAME_LEN);
    send_frame(w, 9'b000000000, 1'b1, FRAME_LEN);
    w = random_words();
    send_frame(w, 9'b100000000, 1'b1, FRAME_LEN);
    send_frame(w, 9'b000000001, 1'b1, FRAME_LEN);
  endtask

  // sentinels map to zero only in their own slots
  task automatic test_sentinel_words();
    srwc_pkg::word_array_t w;
    for (int k = 0; k < srwc_pkg::WORD_COUNT; k++) begin
      w[k] = (k >= 4 && k <= 7) ? srwc_pkg::S_SENTINEL : srwc_pkg::U_SENTINEL;
    end
    send_frame(w, '0, 1'b1, FRAME_LEN);
    for (int k = 0; k < srwc_pkg::WORD_COUNT; k++) begin
      w[k] = (k >= 4 && k <= 7) ? srwc_pkg::U_SENTINEL : srwc_pkg::S_SENTINEL;
    end
    send_frame(w, '0, 1'b1, FRAME_LEN);
    for (int k = 0; k < srwc_pkg::WORD_COUNT; k++) begin
      w[k] = k[0] ? 16'h8000 : 16'h0000;
    end
    send_frame(w, '0, 1'b1, FRAME_LEN);
    for (int k = 0; k < srwc_pkg::WORD_COUNT; k++) begin
      w[k] = k[0] ? 16'hFFFE : 16'h8001;
    end
    send_frame(w, '0, 1'b1, FRAME_LEN);
  endtask

  // frame start mid-response drops the partial frame and its crc error
  task automatic test_frame_restart();
    send_frame(random_words(), 9'b000000001, 1'b1, 10);
    send_frame(random_words(), '0, 1'b1, FRAME_LEN);
    send_frame(random_words(), 9'b011111111, 1'b1, FRAME_LEN - 1);
    send_frame(random_words(), '0, 1'b1, FRAME_LEN);
    send_frame(random_words(), '0, 1'b1, 1);
    send_frame(random_words(), '0, 1'b1, FRAME_LEN);
  endtask

  // after the closing byte the next byte opens a new response by itself
  task automatic test_frame_wrap();
    send_frame(random_words(), '0, 1'b1, FRAME_LEN);
    send_frame(random_words(), '0, 1'b0, FRAME_LEN);
    send_frame(random_words(), 9'b000100000, 1'b0, FRAME_LEN);
    send_frame(random_words(), '0, 1'b0, FRAME_LEN);
  endtask

  // seed extremes, and a seed change in the middle of a word
  task automatic test_seed_register();
    srwc_pkg::word_array_t w;
    logic [7:0]            c;
    write_seed(8'h00);
    send_frame(random_words(), '0, 1'b1, FRAME_LEN);
    write_seed(8'hFF);
    send_frame(random_words(), '0, 1'b1, FRAME_LEN);
    write_seed(8'($urandom));
    send_frame(random_words(), '0, 1'b1, FRAME_LEN);
    // first word keeps the old seed, the rest take the new one
    w = random_words();
    write_seed(8'h5A);
    c = word_crc(w[0]);
    send_byte(w[0][15:8], 1'b1);
    write_seed(8'hA5);
    send_byte(w[0][7:0], 1'b0);
    send_byte(c, 1'b0);
    for (int k = 1; k < srwc_pkg::WORD_COUNT; k++) begin
      c = word_crc(w[k]);
      send_byte(w[k][15:8], 1'b0);
      send_byte(w[k][7:0], 1'b0);
      send_byte(c, 1'b0);
    end
  endtask

  // mostly clean responses, with broken ones, noise and seed changes
  task automatic test_random_traffic();
    int target;
    int sel;
    int n;
    logic [8:0] mask;
    target = bytes_sent + RANDOM_BYTES;
    while (bytes_sent < target) begin
      sel = $urandom_range(0, 99);
      if (sel < 60) begin
        send_frame(random_words(), '0, ($urandom_range(0, 3) != 0), FRAME_LEN);
      end else if (sel < 75) begin
        mask = ($urandom_range(0, 1) != 0) ? (9'd1 << $urandom_range(0, 8))
                                           : 9'($urandom_range(1, 511));
        send_frame(random_words(), mask, 1'b1, FRAME_LEN);
      end else if (sel < 85) begin
        send_frame(random_words(), 9'($urandom), 1'b1, $urandom_range(1, FRAME_LEN - 1));
      end else if (sel < 96) begin
        n = $urandom_range(1, 10);
        repeat (n) send_byte(8'($urandom), ($urandom_range(0, 7) == 0));
      end else begin
        case ($urandom_range(0, 2))
          0: write_seed(8'h00);
          1: write_seed(8'hFF);
          default: write_seed(8'($urandom));
        endcase
      end
    end
  endtask

  initial begin
    reset_model();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_crc_failure();
    test_sentinel_words();
    test_frame_restart();
    test_frame_wrap();
    test_seed_register();
    test_random_traffic();

    // drain
    in_valid <= 1'b0;
    while (pending_readings.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("run covered %0d bytes, %0d good and %0d flagged responses, %0d seed writes",
             bytes_sent, good_results, flagged_results, seed_writes);
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("%0d mismatches", errors);
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
